// ===== rtl/core/sdo_pkg.sv =====
// Shared types, constants and helpers for the swerve drive odometry block.
// No dependencies; everything else in rtl/core imports this package.
package sdo_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int CordicMaxSteps     = 32;

   // CORDIC start gain 0.60725... in Q2.30
   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   // 1/(2 pi) in Q0.32
   localparam logic signed [34:0] InvTwoPi   = 35'sd683565276;
   localparam logic signed [33:0] QuarterTurn = 34'sd1073741824;
   localparam logic signed [33:0] HalfTurn    = 34'sd2147483648;
   localparam logic [15:0]        TickReset   = 16'd655;

   // register indexes
   localparam logic [2:0] CsrWheelRadius = 3'd0;
   localparam logic [2:0] CsrXLeverArm   = 3'd1;
   localparam logic [2:0] CsrYLeverArm   = 3'd2;
   localparam logic [2:0] CsrInvFourRSq  = 3'd3;
   localparam logic [2:0] CsrTickInterval = 3'd4;

   // wheel order of the item
   localparam logic [1:0] WheelFrontRight = 2'd0;
   localparam logic [1:0] WheelFrontLeft  = 2'd1;
   localparam logic [1:0] WheelRearLeft   = 2'd2;
   localparam logic [1:0] WheelRearRight  = 2'd3;

   typedef struct packed {
      logic signed [15:0] front_right_speed;
      logic signed [15:0] front_left_speed;
      logic signed [15:0] rear_left_speed;
      logic signed [15:0] rear_right_speed;
      logic [15:0]        front_right_steer;
      logic [15:0]        front_left_steer;
      logic [15:0]        rear_left_steer;
      logic [15:0]        rear_right_steer;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic [31:0]        pose_heading;
      logic signed [31:0] body_vx;
      logic signed [31:0] body_vy;
      logic signed [31:0] body_omega;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [23:0] data;
   } csr_item_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SPEED,
      S_CINIT,
      S_CRUN,
      S_MCOS,
      S_MSIN,
      S_ACCY,
      S_LEVX,
      S_LEVY,
      S_NSUM,
      S_OMUL,
      S_OSAT,
      S_GAIN,
      S_HRUN,
      S_WX1,
      S_WX2,
      S_WX3,
      S_WY1,
      S_WY2,
      S_PX,
      S_PY,
      S_HD,
      S_DONE
   } sdo_state_type;

   // atan(2^-i) as a 32 bit binary angle
   function automatic logic signed [33:0] arc_angle(input logic [4:0] idx);
      logic signed [33:0] a;
      begin
         case (idx)
            5'd0:  a = 34'sd536870912;
            5'd1:  a = 34'sd316933406;
            5'd2:  a = 34'sd167458907;
            5'd3:  a = 34'sd85004756;
            5'd4:  a = 34'sd42667331;
            5'd5:  a = 34'sd21354465;
            5'd6:  a = 34'sd10679838;
            5'd7:  a = 34'sd5340245;
            5'd8:  a = 34'sd2670163;
            5'd9:  a = 34'sd1335087;
            5'd10: a = 34'sd667544;
            5'd11: a = 34'sd333772;
            5'd12: a = 34'sd166886;
            5'd13: a = 34'sd83443;
            5'd14: a = 34'sd41722;
            5'd15: a = 34'sd20861;
            5'd16: a = 34'sd10430;
            5'd17: a = 34'sd5215;
            5'd18: a = 34'sd2608;
            5'd19: a = 34'sd1304;
            5'd20: a = 34'sd652;
            5'd21: a = 34'sd326;
            5'd22: a = 34'sd163;
            5'd23: a = 34'sd81;
            5'd24: a = 34'sd41;
            5'd25: a = 34'sd20;
            5'd26: a = 34'sd10;
            5'd27: a = 34'sd5;
            5'd28: a = 34'sd3;
            5'd29: a = 34'sd1;
            5'd30: a = 34'sd1;
            default: a = 34'sd0;
         endcase
         return a;
      end
   endfunction

   // round to nearest, ties up, then arithmetic shift
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int unsigned s);
      logic signed [63:0] half;
      begin
         half = 64'sd1 <<< (s - 1);
         return (v + half) >>> s;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      begin
         if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
         end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
         end else begin
            r = v[31:0];
         end
         return r;
      end
   endfunction

endpackage

// ===== rtl/core/sdo_channels.sv =====
// Valid/ready channel interfaces for the swerve drive odometry block.
// Depends on sdo_pkg for the item types.
interface sdo_req_if;
   logic                  valid;
   logic                  ready;
   sdo_pkg::req_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface sdo_rsp_if;
   logic                  valid;
   logic                  ready;
   sdo_pkg::rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface sdo_csr_if;
   logic                  valid;
   logic                  ready;
   sdo_pkg::csr_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/core/swerve_drive_odometry.sv =====
// Swerve drive odometry top level: sequencer, shared multiplier, CORDIC unit.
// Depends on sdo_pkg and the channel interfaces in sdo_channels.sv.
//
//   channel  dir  payload                                     notes
//   req_if   in   4 wheel speeds, 4 steer angles              taken in S_IDLE only
//   rsp_if   out  pose x/y/heading, body vx/vy/omega          one item per req item
//   csr_if   in   register index (3b), data (24b)             always ready
//
// Each item makes four wheel passes of one CORDIC run plus three multiplies
// each, then one CORDIC run on the heading and eleven multiplies, all
// through one 38x35 multiplier and one CORDIC shift/add unit. Synchronous
// active-high reset clears the pose, the registers (tick interval to 655) and
// control. The next item is taken as soon as the result is loaded into the
// output register; if that register is still full, the sequencer waits in
// its last state until rsp_if is ready.
module swerve_drive_odometry #(
   parameter int CORDIC_STEPS = sdo_pkg::CordicStepsDefault
) (
   input logic        clock,
   input logic        reset,
   sdo_req_if.sink    req_if,
   sdo_rsp_if.source  rsp_if,
   sdo_csr_if.sink    csr_if
);
   import sdo_pkg::*;

   localparam int IterW = $clog2(CORDIC_STEPS);
   localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_STEPS - 1);

   sdo_state_type state_ff, state_in;

   // config registers
   logic [19:0] radius_ff, xlev_ff, ylev_ff;
   logic [23:0] inv_ff;
   logic [15:0] tick_ff;

   // pose state
   logic signed [31:0] posx_ff, posx_in, posy_ff, posy_in;
   logic [31:0]        head_ff, head_in;

   // sequencing
   logic [1:0]       wheel_ff, wheel_in;
   logic [IterW-1:0] iter_ff, iter_in;

   // latched item
   logic signed [15:0] speed_ff [4];
   logic [15:0]        steer_ff [4];

   // CORDIC unit
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic               flip_ff, flip_in;
   logic signed [33:0] cos_w, sin_w;

   // datapath registers
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [29:0] vel_ff, vel_in;
   logic signed [33:0] sumx_ff, sumx_in, sumy_ff, sumy_in;
   logic signed [33:0] difx_ff, difx_in, dify_ff, dify_in;
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in, omega_ff, omega_in;
   logic signed [37:0] n_ff, n_in;
   logic signed [34:0] gain_ff, gain_in;
   logic signed [33:0] wx_ff, wx_in, wy_ff, wy_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // shared multiplier
   logic signed [37:0] mul_a;
   logic signed [34:0] mul_b;
   logic signed [72:0] prod_full;

   // rounded views of the product and accumulator
   logic signed [63:0] rp8, rp16, rp30, rsum16, rsum30, rdiff30, rsx2, rsy2;

   logic req_take, rsp_free, cordic_last, x_neg, y_neg;
   logic signed [33:0] fold_z, cz_start;
   logic [31:0]        cordic_angle;

   assign req_take = req_if.valid && (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign cordic_last = (iter_ff == IterLast);

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.item  = rsp_item_ff;

   assign cos_w = flip_ff ? -cx_ff : cx_ff;
   assign sin_w = flip_ff ? -cy_ff : cy_ff;

   // x parts subtract for the left wheels, y parts for the rear wheels
   assign x_neg = (wheel_ff == WheelFrontLeft) || (wheel_ff == WheelRearLeft);
   assign y_neg = (wheel_ff == WheelRearLeft) || (wheel_ff == WheelRearRight);

   assign rp8     = rnd_shift(prod_ff, 8);
   assign rp16    = rnd_shift(prod_ff, 16);
   assign rp30    = rnd_shift(prod_ff, 30);
   assign rsum16  = rnd_shift(acc_ff + prod_ff, 16);
   assign rsum30  = rnd_shift(acc_ff + prod_ff, 30);
   assign rdiff30 = rnd_shift(acc_ff - prod_ff, 30);
   assign rsx2    = rnd_shift(64'(sumx_ff), 2);
   assign rsy2    = rnd_shift(64'(sumy_ff), 2);

   // CORDIC start angle: wheel steer widened to 32 bits, or the heading
   assign cordic_angle = (state_ff == S_GAIN) ? head_ff : {steer_ff[wheel_ff], 16'h0000};
   assign fold_z = 34'(signed'(cordic_angle));
   always_comb begin
      cz_start = fold_z;
      if (fold_z > QuarterTurn) begin
         cz_start = fold_z - HalfTurn;
      end else if (fold_z < -QuarterTurn) begin
         cz_start = fold_z + HalfTurn;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_take) state_in = S_SPEED;
         S_SPEED: state_in = S_CINIT;
         S_CINIT: state_in = S_CRUN;
         S_CRUN:  if (cordic_last) state_in = S_MCOS;
         S_MCOS:  state_in = S_MSIN;
         S_MSIN:  state_in = S_ACCY;
         S_ACCY:  state_in = (wheel_ff == WheelRearRight) ? S_LEVX : S_SPEED;
         S_LEVX:  state_in = S_LEVY;
         S_LEVY:  state_in = S_NSUM;
         S_NSUM:  state_in = S_OMUL;
         S_OMUL:  state_in = S_OSAT;
         S_OSAT:  state_in = S_GAIN;
         S_GAIN:  state_in = S_HRUN;
         S_HRUN:  if (cordic_last) state_in = S_WX1;
         S_WX1:   state_in = S_WX2;
         S_WX2:   state_in = S_WX3;
         S_WX3:   state_in = S_WY1;
         S_WY1:   state_in = S_WY2;
         S_WY2:   state_in = S_PX;
         S_PX:    state_in = S_PY;
         S_PY:    state_in = S_HD;
         S_HD:    state_in = S_DONE;
         S_DONE:  if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SPEED: begin
            mul_a = 38'(speed_ff[wheel_ff]);
            mul_b = 35'(signed'({1'b0, radius_ff}));
         end
         S_MCOS: begin
            mul_a = 38'(vel_ff);
            mul_b = 35'(cos_w);
         end
         S_MSIN: begin
            mul_a = 38'(vel_ff);
            mul_b = 35'(sin_w);
         end
         S_LEVX: begin
            mul_a = 38'(signed'({1'b0, xlev_ff}));
            mul_b = 35'(difx_ff);
         end
         S_LEVY: begin
            mul_a = 38'(signed'({1'b0, ylev_ff}));
            mul_b = 35'(dify_ff);
         end
         S_OMUL: begin
            mul_a = n_ff;
            mul_b = 35'(signed'({1'b0, inv_ff}));
         end
         S_OSAT: begin
            mul_a = 38'(signed'({1'b0, tick_ff}));
            mul_b = InvTwoPi;
         end
         S_WX1: begin
            mul_a = 38'(vx_ff);
            mul_b = 35'(cos_w);
         end
         S_WX2: begin
            mul_a = 38'(vy_ff);
            mul_b = 35'(sin_w);
         end
         S_WX3: begin
            mul_a = 38'(vx_ff);
            mul_b = 35'(sin_w);
         end
         S_WY1: begin
            mul_a = 38'(vy_ff);
            mul_b = 35'(cos_w);
         end
         S_WY2: begin
            mul_a = 38'(wx_ff);
            mul_b = 35'(signed'({1'b0, tick_ff}));
         end
         S_PX: begin
            mul_a = 38'(wy_ff);
            mul_b = 35'(signed'({1'b0, tick_ff}));
         end
         S_PY: begin
            mul_a = 38'(omega_ff);
            mul_b = gain_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_full = mul_a * mul_b;

   // datapath next values
   always_comb begin
      prod_in      = prod_full[63:0];
      acc_in       = acc_ff;
      vel_in       = vel_ff;
      sumx_in      = sumx_ff;
      sumy_in      = sumy_ff;
      difx_in      = difx_ff;
      dify_in      = dify_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      n_in         = n_ff;
      omega_in     = omega_ff;
      gain_in      = gain_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      posx_in      = posx_ff;
      posy_in      = posy_ff;
      head_in      = head_ff;
      wheel_in     = wheel_ff;
      iter_in      = iter_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      flip_in      = flip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_item_in  = rsp_item_ff;

      unique case (state_ff)
         S_IDLE: begin
            wheel_in = WheelFrontRight;
            sumx_in  = '0;
            sumy_in  = '0;
            difx_in  = '0;
            dify_in  = '0;
         end
         S_CINIT, S_GAIN: begin
            if (state_ff == S_CINIT) begin
               vel_in = rp8[29:0];
            end else begin
               gain_in = rp16[34:0];
            end
            cx_in   = CordicGain;
            cy_in   = '0;
            cz_in   = cz_start;
            flip_in = (cz_start != fold_z);
            iter_in = '0;
         end
         S_CRUN, S_HRUN: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - (cy_ff >>> iter_ff);
               cy_in = cy_ff + (cx_ff >>> iter_ff);
               cz_in = cz_ff - arc_angle(5'(iter_ff));
            end else begin
               cx_in = cx_ff + (cy_ff >>> iter_ff);
               cy_in = cy_ff - (cx_ff >>> iter_ff);
               cz_in = cz_ff + arc_angle(5'(iter_ff));
            end
            iter_in = iter_ff + 1'b1;
         end
         S_MSIN: begin
            sumx_in = sumx_ff + rp30[33:0];
            difx_in = x_neg ? difx_ff - rp30[33:0] : difx_ff + rp30[33:0];
         end
         S_ACCY: begin
            sumy_in  = sumy_ff + rp30[33:0];
            dify_in  = y_neg ? dify_ff - rp30[33:0] : dify_ff + rp30[33:0];
            wheel_in = wheel_ff + 1'b1;
         end
         S_LEVX: begin
            vx_in = rsx2[31:0];
            vy_in = rsy2[31:0];
         end
         S_LEVY, S_WX2, S_WY1: acc_in = prod_ff;
         S_NSUM: n_in = rsum16[37:0];
         S_OSAT: omega_in = sat32(rp16);
         S_WX3:  wx_in = rdiff30[33:0];
         S_WY2:  wy_in = rsum30[33:0];
         S_PX:   posx_in = sat32(64'(posx_ff) + rp16);
         S_PY:   posy_in = sat32(64'(posy_ff) + rp16);
         S_HD:   head_in = head_ff + rp16[31:0];
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.pose_x       = posx_ff;
               rsp_item_in.pose_y       = posy_ff;
               rsp_item_in.pose_heading = head_ff;
               rsp_item_in.body_vx      = vx_ff;
               rsp_item_in.body_vy      = vy_ff;
               rsp_item_in.body_omega   = omega_ff;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // control, config and pose
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wheel_ff     <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= '0;
         xlev_ff      <= '0;
         ylev_ff      <= '0;
         inv_ff       <= '0;
         tick_ff      <= TickReset;
         posx_ff      <= '0;
         posy_ff      <= '0;
         head_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         wheel_ff     <= wheel_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         posx_ff      <= posx_in;
         posy_ff      <= posy_in;
         head_ff      <= head_in;
         if (csr_if.valid) begin
            unique case (csr_if.item.index)
               CsrWheelRadius:  radius_ff <= csr_if.item.data[19:0];
               CsrXLeverArm:    xlev_ff   <= csr_if.item.data[19:0];
               CsrYLeverArm:    ylev_ff   <= csr_if.item.data[19:0];
               CsrInvFourRSq:   inv_ff    <= csr_if.item.data;
               CsrTickInterval: tick_ff   <= csr_if.item.data[15:0];
               default:         radius_ff <= radius_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         speed_ff[WheelFrontRight] <= req_if.item.front_right_speed;
         speed_ff[WheelFrontLeft]  <= req_if.item.front_left_speed;
         speed_ff[WheelRearLeft]   <= req_if.item.rear_left_speed;
         speed_ff[WheelRearRight]  <= req_if.item.rear_right_speed;
         steer_ff[WheelFrontRight] <= req_if.item.front_right_steer;
         steer_ff[WheelFrontLeft]  <= req_if.item.front_left_steer;
         steer_ff[WheelRearLeft]   <= req_if.item.rear_left_steer;
         steer_ff[WheelRearRight]  <= req_if.item.rear_right_steer;
      end
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      vel_ff      <= vel_in;
      sumx_ff     <= sumx_in;
      sumy_ff     <= sumy_in;
      difx_ff     <= difx_in;
      dify_ff     <= dify_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      n_ff        <= n_in;
      omega_ff    <= omega_in;
      gain_ff     <= gain_in;
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      flip_ff     <= flip_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule
